### rtl/core/spe_pkg.sv
// shared types and constants of the sign partition engine
`default_nettype none

package spe_pkg;

	localparam int MAX_LEN    = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(MAX_LEN);
	localparam int CNT_W      = $clog2(MAX_LEN + 1);

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	// method register codes
	localparam logic METHOD_TWO_ENDED = 1'b0;
	localparam logic METHOD_FORWARD   = 1'b1;

	// store write request
	typedef struct packed {
		logic  en;
		idx_t  addr;
		word_t data;
	} wr_req_t;

	typedef enum logic [10:0] {
		ST_LOAD     = 11'b000_0000_0001,
		ST_SCAN_L   = 11'b000_0000_0010,
		ST_TEST_L   = 11'b000_0000_0100,
		ST_SCAN_R   = 11'b000_0000_1000,
		ST_TEST_R   = 11'b000_0001_0000,
		ST_FWD_RD   = 11'b000_0010_0000,
		ST_FWD_TEST = 11'b000_0100_0000,
		ST_FWD_GET  = 11'b000_1000_0000,
		ST_SWAP_B   = 11'b001_0000_0000,
		ST_EMIT_RD  = 11'b010_0000_0000,
		ST_EMIT_LD  = 11'b100_0000_0000
	} state_t;

endpackage

`default_nettype wire

### rtl/core/spe_if.sv
// word channels of the sign partition engine
`default_nettype none

interface spe_in_if;
	logic                valid;
	logic                ready;
	spe_pkg::word_t      value;
	logic                is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface spe_out_if;
	logic                valid;
	logic                ready;
	spe_pkg::word_t      value_res;
	logic                is_last_res;
	logic                truncated;

	modport source (output valid, output value_res, output is_last_res, output truncated,
		input ready);
	modport sink   (input valid, input value_res, input is_last_res, input truncated,
		output ready);
endinterface

`default_nettype wire

### rtl/core/spe_store.sv
// element store: one write port, one read port with registered data
`default_nettype none

module spe_store (
	input  wire                     clk,
	input  spe_pkg::wr_req_t        wr,
	input  spe_pkg::idx_t           rd_addr,
	output spe_pkg::word_t          rd_data_q
);

	spe_pkg::word_t mem [spe_pkg::MAX_LEN];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

`default_nettype wire

### rtl/core/sign_partition_engine_core.sv
// sign partition engine: load, partition by sign in place, emit
// load: one word per cycle while input valid; the last word starts partitioning next cycle
// single store read port; two-ended method: SCAN_L/TEST_L or SCAN_R/TEST_R per pointer step,
// SWAP_B per swap; forward method: FWD_RD, FWD_TEST per scanned word, FWD_GET, SWAP_B per
// swap; emit: EMIT_RD, EMIT_LD per word plus output stalls; input ready only while loading
// arst_n clears control state; store contents are not cleared (written before read)
`default_nettype none

module sign_partition_engine_core (
	input  wire                 clk,
	input  wire                 arst_n,
	spe_in_if.sink              in_ch,
	spe_out_if.source           out_ch,
	input  wire                 cfg_we,
	input  wire                 cfg_wdata
);

	spe_pkg::state_t  state_q;
	spe_pkg::cnt_t    cnt_q;        // words held in the store
	logic             ovf_q;        // a word was dropped from this array
	spe_pkg::cnt_t    l_q;          // left pointer / boundary, then emit index
	spe_pkg::cnt_t    r_q;          // right pointer / scan index
	logic             method_q;
	spe_pkg::word_t   hold_q;       // word parked across a swap

	// output register
	logic             out_v_q;
	spe_pkg::word_t   out_val_q;
	logic             out_last_q;
	logic             out_trunc_q;

	spe_pkg::wr_req_t wr;
	spe_pkg::idx_t    rd_addr;
	spe_pkg::word_t   rd_data_q;

	logic             accept;
	logic             room;
	logic             rd_neg;
	logic             l_ge_r;
	logic             emit_last;
	logic             out_free;

	spe_store u_store (
		.clk       (clk),
		.wr        (wr),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data_q)
	);

	assign in_ch.ready = (state_q == spe_pkg::ST_LOAD);
	assign accept      = in_ch.valid && in_ch.ready;
	assign room        = (cnt_q < spe_pkg::CNT_W'(spe_pkg::MAX_LEN));
	assign rd_neg      = rd_data_q[spe_pkg::DATA_WIDTH-1];
	assign l_ge_r      = (l_q >= r_q);
	assign emit_last   = (l_q == (cnt_q - spe_pkg::CNT_W'(1)));
	assign out_free    = !out_v_q || out_ch.ready;

	assign out_ch.valid       = out_v_q;
	assign out_ch.value_res   = out_val_q;
	assign out_ch.is_last_res = out_last_q;
	assign out_ch.truncated   = out_trunc_q;

	// read address: which pointer the next state looks at
	always_comb begin
		unique case (state_q)
			spe_pkg::ST_SCAN_R,
			spe_pkg::ST_FWD_RD:   rd_addr = r_q[spe_pkg::IDX_W-1:0];
			default:              rd_addr = l_q[spe_pkg::IDX_W-1:0];
		endcase
	end

	// store writes: loading, and the two halves of a swap
	always_comb begin
		wr.en   = 1'b0;
		wr.addr = cnt_q[spe_pkg::IDX_W-1:0];
		wr.data = in_ch.value;
		unique case (state_q)
			spe_pkg::ST_LOAD: begin
				wr.en = accept && room;
			end
			spe_pkg::ST_TEST_R: begin
				// right word is negative: it goes to the left slot
				wr.en   = rd_neg;
				wr.addr = l_q[spe_pkg::IDX_W-1:0];
				wr.data = rd_data_q;
			end
			spe_pkg::ST_FWD_GET: begin
				// word from the boundary goes to the scan slot
				wr.en   = 1'b1;
				wr.addr = r_q[spe_pkg::IDX_W-1:0];
				wr.data = rd_data_q;
			end
			spe_pkg::ST_SWAP_B: begin
				wr.en   = 1'b1;
				wr.addr = (method_q == spe_pkg::METHOD_FORWARD) ?
					l_q[spe_pkg::IDX_W-1:0] : r_q[spe_pkg::IDX_W-1:0];
				wr.data = hold_q;
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= spe_pkg::METHOD_TWO_ENDED;
		end else if (cfg_we) begin
			method_q <= cfg_wdata;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == spe_pkg::ST_TEST_L) || (state_q == spe_pkg::ST_FWD_TEST)) begin
			hold_q <= rd_data_q;
		end
		if ((state_q == spe_pkg::ST_EMIT_LD) && out_free) begin
			out_val_q   <= rd_data_q;
			out_last_q  <= emit_last;
			out_trunc_q <= ovf_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spe_pkg::ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			l_q     <= '0;
			r_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			// output register: refilled while emitting, emptied when taken
			if ((state_q == spe_pkg::ST_EMIT_LD) && out_free) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				spe_pkg::ST_LOAD: begin
					if (accept) begin
						if (room) begin
							cnt_q <= cnt_q + spe_pkg::CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_ch.is_last) begin
							l_q <= '0;
							if (method_q == spe_pkg::METHOD_FORWARD) begin
								r_q     <= '0;
								state_q <= spe_pkg::ST_FWD_RD;
							end else begin
								// index of the last stored word
								r_q     <= room ? cnt_q : cnt_q - spe_pkg::CNT_W'(1);
								state_q <= spe_pkg::ST_SCAN_L;
							end
						end
					end
				end
				// two-ended: left pointer skips negatives
				spe_pkg::ST_SCAN_L: begin
					if (l_ge_r) begin
						l_q     <= '0;
						state_q <= spe_pkg::ST_EMIT_RD;
					end else begin
						state_q <= spe_pkg::ST_TEST_L;
					end
				end
				spe_pkg::ST_TEST_L: begin
					if (rd_neg) begin
						l_q     <= l_q + spe_pkg::CNT_W'(1);
						state_q <= spe_pkg::ST_SCAN_L;
					end else begin
						state_q <= spe_pkg::ST_SCAN_R;
					end
				end
				// right pointer skips non-negatives
				spe_pkg::ST_SCAN_R: begin
					if (l_ge_r) begin
						l_q     <= '0;
						state_q <= spe_pkg::ST_EMIT_RD;
					end else begin
						state_q <= spe_pkg::ST_TEST_R;
					end
				end
				spe_pkg::ST_TEST_R: begin
					if (rd_neg) begin
						state_q <= spe_pkg::ST_SWAP_B;
					end else begin
						r_q     <= r_q - spe_pkg::CNT_W'(1);
						state_q <= spe_pkg::ST_SCAN_R;
					end
				end
				// forward scan
				spe_pkg::ST_FWD_RD: begin
					if (r_q >= cnt_q) begin
						l_q     <= '0;
						state_q <= spe_pkg::ST_EMIT_RD;
					end else begin
						state_q <= spe_pkg::ST_FWD_TEST;
					end
				end
				spe_pkg::ST_FWD_TEST: begin
					if (rd_neg && (l_q != r_q)) begin
						state_q <= spe_pkg::ST_FWD_GET;
					end else begin
						if (rd_neg) begin
							l_q <= l_q + spe_pkg::CNT_W'(1);
						end
						r_q     <= r_q + spe_pkg::CNT_W'(1);
						state_q <= spe_pkg::ST_FWD_RD;
					end
				end
				spe_pkg::ST_FWD_GET: begin
					state_q <= spe_pkg::ST_SWAP_B;
				end
				// second write of a swap, then both pointers move
				spe_pkg::ST_SWAP_B: begin
					l_q <= l_q + spe_pkg::CNT_W'(1);
					if (method_q == spe_pkg::METHOD_FORWARD) begin
						r_q     <= r_q + spe_pkg::CNT_W'(1);
						state_q <= spe_pkg::ST_FWD_RD;
					end else begin
						r_q     <= r_q - spe_pkg::CNT_W'(1);
						state_q <= spe_pkg::ST_SCAN_L;
					end
				end
				// emission: read a word, then move it into the output register
				spe_pkg::ST_EMIT_RD: begin
					state_q <= spe_pkg::ST_EMIT_LD;
				end
				spe_pkg::ST_EMIT_LD: begin
					if (out_free) begin
						if (emit_last) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							l_q     <= '0;
							r_q     <= '0;
							state_q <= spe_pkg::ST_LOAD;
						end else begin
							l_q     <= l_q + spe_pkg::CNT_W'(1);
							state_q <= spe_pkg::ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= spe_pkg::ST_LOAD;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// fill count never passes the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= spe_pkg::CNT_W'(spe_pkg::MAX_LEN))
		else $error("element count beyond store depth");

	// swaps only touch words of the current array
	a_swap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && (state_q != spe_pkg::ST_LOAD)) |->
			({1'b0, wr.addr} < cnt_q))
		else $error("swap write outside stored words");

	// the last emitted word returns the engine to loading with an empty store
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == spe_pkg::ST_EMIT_LD) && out_free && emit_last) |=>
			((state_q == spe_pkg::ST_LOAD) && (cnt_q == '0) && !ovf_q
			&& out_v_q && out_last_q))
		else $error("array end did not restart loading");
`endif

endmodule

`default_nettype wire
